/* src/euler_angles_to_rotation_matrix_top_assert.svh */
// ============================================================================
// Euler rotation matrix assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ============================================================================
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_TOP_ASSERT_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_TOP_ASSERT_SVH

`ifndef SYNTH
// clocked check, off while reset is high
`define EUL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("eul: assertion failed");
// clocked check that also runs through reset
`define EUL_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("eul: reset assertion failed");
`else
`define EUL_ASSERT(lbl, clk, rst, prop)
`define EUL_ASSERT_NR(lbl, clk, prop)
`endif

`endif

/* src/eul_pkg.sv */
// ============================================================================
// Euler rotation matrix package
// Payload types, fixed-point constants and rounding helpers.
// ============================================================================
package eul_pkg;

   localparam int ANGLE_WIDTH = 16;
   localparam int COEF_WIDTH  = 16;

   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0] angle_x;
      logic signed [ANGLE_WIDTH-1:0] angle_y;
      logic signed [ANGLE_WIDTH-1:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] m00;
      logic signed [COEF_WIDTH-1:0] m01;
      logic signed [COEF_WIDTH-1:0] m02;
      logic signed [COEF_WIDTH-1:0] m10;
      logic signed [COEF_WIDTH-1:0] m11;
      logic signed [COEF_WIDTH-1:0] m12;
      logic signed [COEF_WIDTH-1:0] m20;
      logic signed [COEF_WIDTH-1:0] m21;
      logic signed [COEF_WIDTH-1:0] m22;
   } rsp_type;

   // sin/cos in Q30, sign included
   typedef logic signed [31:0] trig_type;

   typedef struct packed {
      trig_type sx;
      trig_type cx;
      trig_type sy;
      trig_type cy;
      trig_type sz;
      trig_type cz;
   } trig_set_type;

   localparam int PRE_W = 34;

   typedef struct packed {
      logic signed [PRE_W-1:0] m00;
      logic signed [PRE_W-1:0] m01;
      logic signed [PRE_W-1:0] m02;
      logic signed [PRE_W-1:0] m10;
      logic signed [PRE_W-1:0] m11;
      logic signed [PRE_W-1:0] m12;
      logic signed [PRE_W-1:0] m20;
      logic signed [PRE_W-1:0] m21;
      logic signed [PRE_W-1:0] m22;
   } pre_type;

   // reduced argument and quadrant info that rides along the series
   localparam int X_W = 31;
   typedef struct packed {
      logic [X_W-1:0] x;
      logic [2:0]     quad;
      logic           neg;
      logic           rneg;
   } side_type;

   localparam logic [35:0] HALFPI_Q32 = 36'd6746518852;
   localparam logic [35:0] HALFPI_HALF = HALFPI_Q32 / 2;
   localparam logic [35:0] QH_TBL [6] = '{
      36'd0, HALFPI_Q32, 36'(2 * HALFPI_Q32), 36'(3 * HALFPI_Q32),
      36'(4 * HALFPI_Q32), 36'(5 * HALFPI_Q32)};
   // round-to-nearest quadrant thresholds
   localparam logic [35:0] THR_TBL [5] = '{
      36'(HALFPI_Q32 - HALFPI_HALF), 36'(2 * HALFPI_Q32 - HALFPI_HALF),
      36'(3 * HALFPI_Q32 - HALFPI_HALF), 36'(4 * HALFPI_Q32 - HALFPI_HALF),
      36'(5 * HALFPI_Q32 - HALFPI_HALF)};

   localparam logic [X_W-1:0] ONE_Q30 = X_W'(1 << 30);

   // Taylor divisors: sine steps first, then cosine steps
   localparam int SIN_STEPS   = 6;
   localparam int COS_STEPS   = 7;
   localparam int DIV_N       = SIN_STEPS + COS_STEPS;
   localparam int DIV_SEL_W   = $clog2(DIV_N);
   localparam logic [7:0] DIV_TBL [DIV_N] = '{
      8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
      8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
   localparam logic [63:0] TWO32 = 64'h1_0000_0000;
   localparam logic [31:0] RECIP_TBL [DIV_N] = '{
      32'(TWO32 / 156), 32'(TWO32 / 110), 32'(TWO32 / 72), 32'(TWO32 / 42),
      32'(TWO32 / 20), 32'(TWO32 / 6), 32'(TWO32 / 182), 32'(TWO32 / 132),
      32'(TWO32 / 90), 32'(TWO32 / 56), 32'(TWO32 / 30), 32'(TWO32 / 12),
      32'(TWO32 / 2)};

   // pipeline depths
   localparam int STEP_STAGES  = 3;
   localparam int SERIES_BASE  = 4;
   localparam int SIN_TAIL     = SERIES_BASE + SIN_STEPS * STEP_STAGES;
   localparam int LANE_STAGES  = SERIES_BASE + COS_STEPS * STEP_STAGES + 1;
   localparam int MERGE_STAGES = 4;
   localparam int LANE_BASE    = 1;
   localparam int MERGE_BASE   = LANE_BASE + LANE_STAGES;
   localparam int PIPE_STAGES  = MERGE_BASE + MERGE_STAGES + 1;

   localparam int COEF_SH  = 32 - COEF_WIDTH;
   localparam int COEF_LIM = 1 << (COEF_WIDTH - 2);

   // Q60 product to Q30, half away from zero
   function automatic trig_type rnd_q30(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] rs;
      mag = v[63] ? 64'(-v) : 64'(v);
      rs  = (mag + 64'(1 << 29)) >> 30;
      return v[63] ? -$signed(rs[31:0]) : $signed(rs[31:0]);
   endfunction

   // Q30 to output format, half away from zero, saturated to +-1
   function automatic logic signed [COEF_WIDTH-1:0] to_coef(
      input logic signed [PRE_W-1:0] v);
      logic [PRE_W-1:0] mag;
      logic [PRE_W-1:0] o;
      mag = v[PRE_W-1] ? PRE_W'(-v) : PRE_W'(v);
      o   = (mag + PRE_W'(1 << (COEF_SH - 1))) >> COEF_SH;
      if (o > PRE_W'(COEF_LIM)) begin
         o = PRE_W'(COEF_LIM);
      end
      return v[PRE_W-1] ? COEF_WIDTH'(-o) : COEF_WIDTH'(o);
   endfunction

endpackage

/* src/eul_step.sv */
// ============================================================================
// Series step
// One Horner step t' = 1 - round(round(x2*t) / d), three stages.
// ============================================================================
module eul_step
   import eul_pkg::*;
(
   input  logic                 clock,
   input  logic [2:0]           en,
   input  logic [DIV_SEL_W-1:0] div_sel,
   input  logic [X_W-1:0]       x2_i,
   input  logic [X_W-1:0]       t_i,
   input  side_type             side_i,
   output logic [X_W-1:0]       x2_o,
   output logic [X_W-1:0]       t_o,
   output side_type             side_o
);

   logic [7:0]       d;
   logic [31:0]      recip;
   logic [61:0]      pr_ff, pr_in;
   logic [X_W-1:0]   x2a_ff, x2b_ff, x2c_ff;
   side_type         sidea_ff, sideb_ff, sidec_ff;
   logic [61:0]      prs;
   logic [31:0]      n_in, n_ff;
   logic [63:0]      qm;
   logic [31:0]      q0_ff;
   logic [39:0]      qd, rem;
   logic [31:0]      q;
   logic [X_W-1:0]   t_in, t_ff;

   assign d     = DIV_TBL[div_sel];
   assign recip = RECIP_TBL[div_sel];

   assign pr_in = 62'(x2_i) * 62'(t_i);

   // reciprocal estimate is low by at most one
   assign prs  = pr_ff + 62'(1 << 29);
   assign n_in = 32'(prs[60:30]) + 32'(d >> 1);
   assign qm   = 64'(n_in) * 64'(recip);

   assign qd   = 40'(q0_ff) * 40'(d);
   assign rem  = 40'(n_ff) - qd;
   assign q    = q0_ff + 32'(rem >= 40'(d));
   assign t_in = X_W'(32'(ONE_Q30) - q);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pr_ff    <= pr_in;
         x2a_ff   <= x2_i;
         sidea_ff <= side_i;
      end
      if (en[1]) begin
         n_ff     <= n_in;
         q0_ff    <= qm[63:32];
         x2b_ff   <= x2a_ff;
         sideb_ff <= sidea_ff;
      end
      if (en[2]) begin
         t_ff     <= t_in;
         x2c_ff   <= x2b_ff;
         sidec_ff <= sideb_ff;
      end
   end

   assign x2_o   = x2c_ff;
   assign t_o    = t_ff;
   assign side_o = sidec_ff;

endmodule

/* src/eul_lane.sv */
// ============================================================================
// Trig lane
// Sine and cosine of one angle: range reduction, series, quadrant fix.
// ============================================================================
module eul_lane
   import eul_pkg::*;
(
   input  logic                          clock,
   input  logic [LANE_STAGES-1:0]        en,
   input  logic signed [ANGLE_WIDTH-1:0] angle,
   output trig_type                      sin_o,
   output trig_type                      cos_o
);

   logic                   neg;
   logic [ANGLE_WIDTH-1:0] mag;
   logic [35:0]            m32, m32_ff;
   logic [2:0]             quad, quad0_ff;
   logic                   neg0_ff;
   logic signed [37:0]     r;
   logic [37:0]            rmag, rsum;
   side_type               side1_in, side1_ff, side2_ff, side3_ff;
   logic [61:0]            sq_ff, sqs;
   logic [X_W-1:0]         x2_ff;

   logic [X_W-1:0]         sx2 [SIN_STEPS+1];
   logic [X_W-1:0]         st  [SIN_STEPS+1];
   side_type               ss  [SIN_STEPS+1];
   logic [X_W-1:0]         cx2 [COS_STEPS+1];
   logic [X_W-1:0]         ct  [COS_STEPS+1];
   side_type               cs  [COS_STEPS+1];

   logic [61:0]            sp_ff, sps;
   logic [X_W-1:0]         s0_ff, s0d_ff;
   trig_type               s0s, c0, s_q, c_q, sin_ff, cos_ff;

   // stage 0: magnitude and nearest quadrant
   always_comb begin
      neg  = angle[ANGLE_WIDTH-1];
      mag  = neg ? ANGLE_WIDTH'(-angle) : ANGLE_WIDTH'(angle);
      m32  = {mag, {(36 - ANGLE_WIDTH){1'b0}}};
      quad = '0;
      for (int k = 0; k < 5; k++) begin
         quad = quad + 3'(m32 >= THR_TBL[k]);
      end
   end

   // stage 1: remainder to Q30
   always_comb begin
      r    = $signed({2'b00, m32_ff}) - $signed({2'b00, QH_TBL[quad0_ff]});
      rmag = r[37] ? 38'(-r) : 38'(r);
      rsum = rmag + 38'd2;
      side1_in.x    = rsum[32:2];
      side1_in.quad = quad0_ff;
      side1_in.neg  = neg0_ff;
      side1_in.rneg = r[37];
   end

   assign sqs = sq_ff + 62'(1 << 29);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         m32_ff   <= m32;
         quad0_ff <= quad;
         neg0_ff  <= neg;
      end
      if (en[1]) begin
         side1_ff <= side1_in;
      end
      if (en[2]) begin
         sq_ff    <= 62'(side1_ff.x) * 62'(side1_ff.x);
         side2_ff <= side1_ff;
      end
      if (en[3]) begin
         x2_ff    <= sqs[60:30];
         side3_ff <= side2_ff;
      end
   end

   assign sx2[0] = x2_ff;
   assign st[0]  = ONE_Q30;
   assign ss[0]  = side3_ff;
   assign cx2[0] = x2_ff;
   assign ct[0]  = ONE_Q30;
   assign cs[0]  = side3_ff;

   for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
      eul_step u_step (
         .clock   (clock),
         .en      (en[SERIES_BASE + STEP_STAGES * i +: STEP_STAGES]),
         .div_sel (DIV_SEL_W'(i)),
         .x2_i    (sx2[i]),
         .t_i     (st[i]),
         .side_i  (ss[i]),
         .x2_o    (sx2[i+1]),
         .t_o     (st[i+1]),
         .side_o  (ss[i+1])
      );
   end

   for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
      eul_step u_step (
         .clock   (clock),
         .en      (en[SERIES_BASE + STEP_STAGES * i +: STEP_STAGES]),
         .div_sel (DIV_SEL_W'(SIN_STEPS + i)),
         .x2_i    (cx2[i]),
         .t_i     (ct[i]),
         .side_i  (cs[i]),
         .x2_o    (cx2[i+1]),
         .t_o     (ct[i+1]),
         .side_o  (cs[i+1])
      );
   end

   // sine tail: x * series, round, then wait for the last cosine step
   assign sps = sp_ff + 62'(1 << 29);

   always_ff @(posedge clock) begin
      if (en[SIN_TAIL]) begin
         sp_ff <= 62'(ss[SIN_STEPS].x) * 62'(st[SIN_STEPS]);
      end
      if (en[SIN_TAIL + 1]) begin
         s0_ff <= sps[60:30];
      end
      if (en[SIN_TAIL + 2]) begin
         s0d_ff <= s0_ff;
      end
   end

   // quadrant restore and angle sign
   always_comb begin
      s0s = {1'b0, s0d_ff};
      if (cs[COS_STEPS].rneg) begin
         s0s = -s0s;
      end
      c0 = {1'b0, ct[COS_STEPS]};
      case (cs[COS_STEPS].quad[1:0])
         2'd0: begin
            s_q = s0s;
            c_q = c0;
         end
         2'd1: begin
            s_q = c0;
            c_q = -s0s;
         end
         2'd2: begin
            s_q = -s0s;
            c_q = -c0;
         end
         default: begin
            s_q = -c0;
            c_q = s0s;
         end
      endcase
      if (cs[COS_STEPS].neg) begin
         s_q = -s_q;
      end
   end

   always_ff @(posedge clock) begin
      if (en[LANE_STAGES-1]) begin
         sin_ff <= s_q;
         cos_ff <= c_q;
      end
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;

endmodule

/* src/eul_merge.sv */
// ============================================================================
// Matrix merge
// Combines the three lanes' sin/cos into the nine Q30 rotation entries.
// ============================================================================
module eul_merge
   import eul_pkg::*;
(
   input  logic                    clock,
   input  logic [MERGE_STAGES-1:0] en,
   input  trig_set_type            trig_i,
   output pre_type                 pre_o
);

   localparam int NPROD = 12;

   logic signed [63:0] pa_ff, pb_ff;
   trig_set_type       tr0_ff, tr1_ff, tr2_ff;
   trig_type           sysx_ff, sycx_ff;
   logic signed [63:0] pr_in [NPROD];
   logic signed [63:0] pr_ff [NPROD];
   trig_type           rp [NPROD];
   pre_type            pre_in, pre_ff;

   always_comb begin
      pr_in[0]  = tr1_ff.cz * tr1_ff.cy;
      pr_in[1]  = tr1_ff.cz * sysx_ff;
      pr_in[2]  = tr1_ff.sz * tr1_ff.cx;
      pr_in[3]  = tr1_ff.cz * sycx_ff;
      pr_in[4]  = tr1_ff.sz * tr1_ff.sx;
      pr_in[5]  = tr1_ff.sz * tr1_ff.cy;
      pr_in[6]  = tr1_ff.sz * sysx_ff;
      pr_in[7]  = tr1_ff.cz * tr1_ff.cx;
      pr_in[8]  = tr1_ff.sz * sycx_ff;
      pr_in[9]  = tr1_ff.cz * tr1_ff.sx;
      pr_in[10] = tr1_ff.cy * tr1_ff.sx;
      pr_in[11] = tr1_ff.cy * tr1_ff.cx;
   end

   always_comb begin
      for (int i = 0; i < NPROD; i++) begin
         rp[i] = rnd_q30(pr_ff[i]);
      end
      pre_in.m00 = PRE_W'(rp[0]);
      pre_in.m01 = PRE_W'(rp[1]) - PRE_W'(rp[2]);
      pre_in.m02 = PRE_W'(rp[3]) + PRE_W'(rp[4]);
      pre_in.m10 = PRE_W'(rp[5]);
      pre_in.m11 = PRE_W'(rp[6]) + PRE_W'(rp[7]);
      pre_in.m12 = PRE_W'(rp[8]) - PRE_W'(rp[9]);
      pre_in.m20 = -PRE_W'(tr2_ff.sy);
      pre_in.m21 = PRE_W'(rp[10]);
      pre_in.m22 = PRE_W'(rp[11]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pa_ff  <= trig_i.sy * trig_i.sx;
         pb_ff  <= trig_i.sy * trig_i.cx;
         tr0_ff <= trig_i;
      end
      if (en[1]) begin
         sysx_ff <= rnd_q30(pa_ff);
         sycx_ff <= rnd_q30(pb_ff);
         tr1_ff  <= tr0_ff;
      end
      if (en[2]) begin
         pr_ff  <= pr_in;
         tr2_ff <= tr1_ff;
      end
      if (en[3]) begin
         pre_ff <= pre_in;
      end
   end

   assign pre_o = pre_ff;

endmodule

/* src/euler_angles_to_rotation_matrix_top.sv */
// ============================================================================
// Euler Z-Y-X rotation matrix
// Angle triple in, 3x3 rotation matrix R = Rz*Ry*Rx out.
// ============================================================================
// Usage:
//   req_* channel: one beat carries angle_x/y/z, signed Q4.12 radians.
//   rsp_* channel: one beat carries m00..m22, signed Q1.14, saturated to +-1.
//   Both channels are valid/ready; a beat moves when valid and ready are high.
// Timing:
//   Fully pipelined, 32 register stages, input register first, rsp last.
//   One beat per cycle sustained while rsp_ready is high. Depth is set by
//   the Taylor series: seven cosine steps of three stages each (multiply,
//   reciprocal multiply, divide correction) in each of three trig lanes.
// Reset:
//   Synchronous, active high; empties every stage. No state across beats.
// Backpressure:
//   A stalled rsp side only holds the stages that are full behind it; bubbles
//   still collapse, so req_ready stays high until every stage holds a beat.
// ============================================================================
`include "euler_angles_to_rotation_matrix_top_assert.svh"

module euler_angles_to_rotation_matrix_top
   import eul_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic signed [COEF_WIDTH-1:0] SAT = COEF_WIDTH'(COEF_LIM);

   // one valid bit per stage; stage 0 is the input register, last is rsp
   logic [PIPE_STAGES-1:0] v_ff, v_in;
   logic [PIPE_STAGES-1:0] adv;
   req_type                req_ff;
   trig_set_type           trig;
   pre_type                pre;
   rsp_type                rsp_ff, rsp_in;

   // a stage may load when some stage at or after it is empty, or rsp drains
   always_comb begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
         adv[i] = rsp_ready ||
                  !(&(v_ff | ({PIPE_STAGES{1'b1}} >> (PIPE_STAGES - i))));
      end
   end

   always_comb begin
      v_in[0] = adv[0] ? req_valid : v_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         v_in[i] = adv[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         req_ff <= req_data;
      end
   end

   // three trig lanes, one per axis
   eul_lane u_lane_x (
      .clock (clock),
      .en    (adv[LANE_BASE +: LANE_STAGES]),
      .angle (req_ff.angle_x),
      .sin_o (trig.sx),
      .cos_o (trig.cx)
   );

   eul_lane u_lane_y (
      .clock (clock),
      .en    (adv[LANE_BASE +: LANE_STAGES]),
      .angle (req_ff.angle_y),
      .sin_o (trig.sy),
      .cos_o (trig.cy)
   );

   eul_lane u_lane_z (
      .clock (clock),
      .en    (adv[LANE_BASE +: LANE_STAGES]),
      .angle (req_ff.angle_z),
      .sin_o (trig.sz),
      .cos_o (trig.cz)
   );

   eul_merge u_merge (
      .clock  (clock),
      .en     (adv[MERGE_BASE +: MERGE_STAGES]),
      .trig_i (trig),
      .pre_o  (pre)
   );

   // final rounding to Q1.14 with saturation
   always_comb begin
      rsp_in.m00 = to_coef(pre.m00);
      rsp_in.m01 = to_coef(pre.m01);
      rsp_in.m02 = to_coef(pre.m02);
      rsp_in.m10 = to_coef(pre.m10);
      rsp_in.m11 = to_coef(pre.m11);
      rsp_in.m12 = to_coef(pre.m12);
      rsp_in.m20 = to_coef(pre.m20);
      rsp_in.m21 = to_coef(pre.m21);
      rsp_in.m22 = to_coef(pre.m22);
   end

   always_ff @(posedge clock) begin
      if (adv[PIPE_STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = v_ff[PIPE_STAGES-1];
   assign rsp_data  = rsp_ff;

   // input stalls only with every stage full and rsp blocked
   `EUL_ASSERT(a_stall_full, clock, reset, !req_ready |-> ((&v_ff) && !rsp_ready))
   // a beat one stage from the output always leaves rsp_valid high next cycle
   `EUL_ASSERT(a_last_adv, clock, reset, v_ff[PIPE_STAGES-2] |=> rsp_valid)
   // reset empties the whole pipeline
   `EUL_ASSERT_NR(a_reset_empty, clock, reset |=> (v_ff == '0))
   // saturation keeps entries within +-1 (checked here on m00)
   `EUL_ASSERT(a_sat, clock, reset, rsp_valid |-> (rsp_data.m00 <= SAT && rsp_data.m00 >= -SAT))

endmodule

/* tb/euler_angles_to_rotation_matrix_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// Euler rotation matrix checker
// Watches both channels, predicts each matrix from the accepted angles and
// compares every returned beat entry by entry, in order.
// ============================================================================
module euler_angles_to_rotation_matrix_checker
   import eul_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      pending_count,
   output int      angles_taken,
   output int      matrices_seen
);

   localparam longint unsigned QUARTER_TURN = 64'd6746518852;
   localparam longint unsigned UNIT_Q30     = 64'd1 << 30;
   localparam int              COEF_ONE     = 1 << (COEF_WIDTH - 2);

   rsp_type expected_matrices[$];
   string   entry_names[9] = '{"m22", "m21", "m20", "m12", "m11", "m10",
                               "m02", "m01", "m00"};

   function automatic longint round_shift(longint v, int sh);
      longint unsigned mag;
      mag = (v < 0) ? longint'(-v) : v;
      mag = (mag + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic longint q30_mul(longint a, longint b);
      return round_shift(a * b, 30);
   endfunction

   // Horner evaluation of the truncated Taylor series, Q30
   function automatic longint unsigned taylor_poly(longint unsigned x2, bit cosine);
      longint unsigned t;
      longint unsigned p;
      longint unsigned d;
      int              n;
      t = UNIT_Q30;
      n = cosine ? 7 : 6;
      for (int i = 0; i < n; i++) begin
         case (i)
            0: d = cosine ? 182 : 156;
            1: d = cosine ? 132 : 110;
            2: d = cosine ? 90 : 72;
            3: d = cosine ? 56 : 42;
            4: d = cosine ? 30 : 20;
            5: d = cosine ? 12 : 6;
            default: d = 2;
         endcase
         p = (x2 * t + (64'd1 << 29)) >> 30;
         t = UNIT_Q30 - (p + d / 2) / d;
      end
      return t;
   endfunction

   function automatic void sincos_of_angle(input logic [ANGLE_WIDTH-1:0] raw,
                                           output longint s, output longint c);
      longint unsigned mag;
      longint unsigned m32;
      longint unsigned q;
      longint unsigned x;
      longint unsigned x2;
      longint          r;
      longint          s0;
      longint          c0;
      bit              neg;
      neg = raw[ANGLE_WIDTH-1];
      mag = neg ? (64'd1 << ANGLE_WIDTH) - raw : raw;
      m32 = mag << (36 - ANGLE_WIDTH);
      q   = (m32 + QUARTER_TURN / 2) / QUARTER_TURN;
      r   = longint'(m32) - longint'(q * QUARTER_TURN);
      x   = ((r < 0 ? longint'(-r) : r) + 2) >> 2;
      x2  = (x * x + (64'd1 << 29)) >> 30;
      s0  = (x * taylor_poly(x2, 1'b0) + (64'd1 << 29)) >> 30;
      c0  = taylor_poly(x2, 1'b1);
      if (r < 0) s0 = -s0;
      case (q[1:0])
         2'd0: begin s = s0;  c = c0;  end
         2'd1: begin s = c0;  c = -s0; end
         2'd2: begin s = -s0; c = -c0; end
         default: begin s = -c0; c = s0; end
      endcase
      if (neg) s = -s;
   endfunction

   function automatic logic [COEF_WIDTH-1:0] sat_coef(longint v);
      longint o;
      o = round_shift(v, 32 - COEF_WIDTH);
      if (o > COEF_ONE) o = COEF_ONE;
      if (o < -COEF_ONE) o = -COEF_ONE;
      return o[COEF_WIDTH-1:0];
   endfunction

   function automatic rsp_type rotation_of_angles(req_type a);
      longint  sx, cx, sy, cy, sz, cz, sysx, sycx;
      rsp_type m;
      sincos_of_angle(a.angle_x, sx, cx);
      sincos_of_angle(a.angle_y, sy, cy);
      sincos_of_angle(a.angle_z, sz, cz);
      sysx  = q30_mul(sy, sx);
      sycx  = q30_mul(sy, cx);
      m.m00 = sat_coef(q30_mul(cz, cy));
      m.m01 = sat_coef(q30_mul(cz, sysx) - q30_mul(sz, cx));
      m.m02 = sat_coef(q30_mul(cz, sycx) + q30_mul(sz, sx));
      m.m10 = sat_coef(q30_mul(sz, cy));
      m.m11 = sat_coef(q30_mul(sz, sysx) + q30_mul(cz, cx));
      m.m12 = sat_coef(q30_mul(sz, sycx) - q30_mul(cz, sx));
      m.m20 = sat_coef(-sy);
      m.m21 = sat_coef(q30_mul(cy, sx));
      m.m22 = sat_coef(q30_mul(cy, cx));
      return m;
   endfunction

   assign pending_count = expected_matrices.size();

   always @(posedge clock) begin
      rsp_type                          want;
      logic [8:0][COEF_WIDTH-1:0]       want_w;
      logic [8:0][COEF_WIDTH-1:0]       got_w;
      if (reset) begin
         mismatch_count <= 0;
         angles_taken   <= 0;
         matrices_seen  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_matrices.push_back(rotation_of_angles(req_data));
            angles_taken <= angles_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            matrices_seen <= matrices_seen + 1;
            if (expected_matrices.size() == 0) begin
               if (mismatch_count < 10)
                  $display("ERROR: unexpected matrix beat %h", rsp_data);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want   = expected_matrices.pop_front();
               want_w = want;
               got_w  = rsp_data;
               if (want_w != got_w) begin
                  if (mismatch_count < 10)
                     for (int k = 8; k >= 0; k--)
                        if (want_w[k] != got_w[k])
                           $display("ERROR: beat %0d %s expected %0d got %0d",
                                    matrices_seen, entry_names[k],
                                    $signed(want_w[k]), $signed(got_w[k]));
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
   end

endmodule

/* tb/euler_angles_to_rotation_matrix_top_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// Euler rotation matrix regression
// Directed corner angles, then random triples through four idle/stall
// phases and one long output hold-off; the checker scores every matrix.
// ============================================================================
module euler_angles_to_rotation_matrix_top_test;
   import eul_pkg::*;

   localparam int RANDOM_BEATS = 1500;
   localparam int PIPE_DEPTH   = 40;   // a bit over the 32 stages

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int pending_count;
   int angles_taken;
   int matrices_seen;

   // idle percentages, changed per phase by the stimulus
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   logic hold_off     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   euler_angles_to_rotation_matrix_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   euler_angles_to_rotation_matrix_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count),
      .angles_taken  (angles_taken),
      .matrices_seen (matrices_seen)
   );

   // receiver: random stalls per phase, forced low during the hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
   end

   // long hold-off once the run is under way; the sender keeps pushing
   // (no idling in that phase) so the pipe fills and req_ready drops
   initial begin
      wait (angles_taken >= 60);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   // one beat on the request side; valid stays up until taken
   task automatic send_angles(input logic [15:0] ax, ay, az);
      req_type beat;
      beat.angle_x = ax;
      beat.angle_y = ay;
      beat.angle_z = az;
      req_valid <= 1'b1;
      req_data  <= beat;
      // ready is settled by the falling edge; the next rising edge takes it
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] random_angle();
      case ($urandom_range(7))
         0:       return 16'($signed(13'($urandom)));   // small, near zero
         1:       return 16'($urandom_range(12868 + 8, 12868 - 8));
         default: return 16'($urandom);                  // full range
      endcase
   endfunction

   initial begin
      logic [15:0] corners[12] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8001,
                                   16'd6434, -16'd6434, 16'd12868, -16'd12868,
                                   16'd3217, 16'd3218, 16'd19302, 16'hFFFF};
      int beats;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: each corner on every axis, plus a few mixed triples
      for (int i = 0; i < 12; i++)
         send_angles(corners[i], corners[(i + 4) % 12], corners[(i + 7) % 12]);
      send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_angles(16'h8000, 16'h8000, 16'h8000);
      send_angles(16'd6434, 16'd6434, 16'd6434);   // gimbal lock, +pi/2 pitch
      send_angles(16'd0, -16'd6434, 16'd3217);     // gimbal lock, -pi/2 pitch
      send_angles(16'd9651, 16'd9652, 16'd16085);  // half-quadrant boundaries

      // random: four phases of idling
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         beats = RANDOM_BEATS / 4;
         for (int n = 0; n < beats; n++)
            send_angles(random_angle(), random_angle(), random_angle());
      end
      req_valid <= 1'b0;
      stall_pct = 0;

      while (pending_count != 0) @(posedge clock);
      repeat (PIPE_DEPTH) @(posedge clock);

      $display("Run covered %0d angle triples and %0d matrices,", angles_taken,
               matrices_seen);
      $display("corner angles, four idle/stall mixes and a full-pipe hold-off.");
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5ms;
      $display("ERROR: timeout with %0d matrices outstanding", pending_count);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/eul_pkg.sv
src/eul_step.sv
src/eul_lane.sv
src/eul_merge.sv
src/euler_angles_to_rotation_matrix_top.sv
tb/euler_angles_to_rotation_matrix_checker.sv
tb/euler_angles_to_rotation_matrix_top_test.sv
